/* rtl/pam_pkg.sv */
// shared types and constants for the polygon area and moments block
package pam_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COORD_BITS_DEF   = 12;

	localparam int COORD_W   = 12;
	localparam int CROSS_W   = 25;
	localparam int TERM_W    = 26;
	localparam int MUL_W     = 26;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int AREA_W    = 36;
	localparam int AXIS_W    = 60;
	localparam int PRODSUM_W = 61;
	localparam int AREA_OUT_W = 34;
	localparam int MOM_OUT_W  = 54;

	// sums are shifted right by 2 or 3, then divided by three 16 bits per cycle
	localparam int DIV_BITS  = 64;
	localparam int DIV_DIGIT = 16;
	localparam int DIV_STEPS = DIV_BITS / DIV_DIGIT;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	// ceil(2**19 / 3), exact digit quotient for any partial dividend below 3 * 2**16
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = DIV_DIGIT + 3;
	localparam logic [RECIP_W-1:0] RECIP_3 = 18'd174763;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic                      close;
		logic                      ovf;
		logic signed [COORD_W-1:0] xp;
		logic signed [COORD_W-1:0] yp;
		logic signed [COORD_W-1:0] xc;
		logic signed [COORD_W-1:0] yc;
	} edge_t;

	typedef enum logic [3:0] {
		STEP_XPYC,
		STEP_XCYP,
		STEP_YPYP,
		STEP_YPYC,
		STEP_YCYC,
		STEP_XPXP,
		STEP_XPXC,
		STEP_XCXC,
		STEP_XPYP,
		STEP_XCYC,
		STEP_MX,
		STEP_MY,
		STEP_MP
	} step_t;

	typedef enum logic [2:0] {
		BK_RUN,
		BK_DRAIN,
		BK_ABS,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

/* rtl/polygon_area_and_moments.sv */
// Polygon area and second moments: vertices are pushed one per transfer through a queue-style
// port, the last one flagged. The front end takes a vertex in any cycle in which full is low and
// places an edge item (none for the first vertex) in a four-entry queue; the back end works each
// edge through steps STEP_XPYC to STEP_MP on one shared 26x26 multiplier, taking the next item
// only after the last step. The last vertex adds a closing item of STEP_XPYC and STEP_XCYP;
// the sums are then made absolute and the moment sums divided by three 16 bits per cycle via the
// drain, absolute, divide and done states. The result waits in an output register until popped
// while the next polygon is already being taken in; a second result waits in the back end until
// the first is popped, and the queue backs up meanwhile. Coordinates use their low COORD_BITS
// bits, sign-extended; vertices beyond MAX_VERTICES are dropped and flagged in overflow.
module polygon_area_and_moments #(
	parameter int MAX_VERTICES = pam_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = pam_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic signed [pam_pkg::COORD_W-1:0] x_coord,
	input  logic signed [pam_pkg::COORD_W-1:0] y_coord,
	input  logic                               last_vertex,
	output logic                               empty,
	input  logic                               pop,
	output logic [pam_pkg::AREA_OUT_W-1:0]     twice_area,
	output logic [pam_pkg::MOM_OUT_W-1:0]      moment_about_x,
	output logic [pam_pkg::MOM_OUT_W-1:0]      moment_about_y,
	output logic [pam_pkg::MOM_OUT_W-1:0]      product_moment,
	output logic                               overflow
);
	import pam_pkg::*;

	logic  q_wr, q_full, q_rd, q_empty;
	edge_t q_wdata, q_rdata;

	pam_front #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.last_vertex(last_vertex),
		.q_wr       (q_wr),
		.q_wdata    (q_wdata),
		.q_full     (q_full)
	);

	pam_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wdata (q_wdata),
		.full  (q_full),
		.rd    (q_rd),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	pam_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_rdata       (q_rdata),
		.q_empty       (q_empty),
		.q_rd          (q_rd),
		.empty         (empty),
		.pop           (pop),
		.twice_area    (twice_area),
		.moment_about_x(moment_about_x),
		.moment_about_y(moment_about_y),
		.product_moment(product_moment),
		.overflow      (overflow)
	);

endmodule

/* rtl/pam_front.sv */
// vertex front end: tracks first and previous vertex, emits edge and closing items
module pam_front #(
	parameter int MAX_VERTICES = pam_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = pam_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic signed [pam_pkg::COORD_W-1:0] x_coord,
	input  logic signed [pam_pkg::COORD_W-1:0] y_coord,
	input  logic                               last_vertex,
	output logic                               q_wr,
	output pam_pkg::edge_t                     q_wdata,
	input  logic                               q_full
);
	import pam_pkg::*;

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int SHIFT = COORD_W - COORD_BITS;

	logic signed [COORD_W-1:0] x_sh, y_sh, x_v, y_v;
	logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_W-1:0] prev_nx, prev_ny, first_nx, first_ny;
	logic [CNT_W-1:0] cnt_q;
	logic ovf_q, pend_q;
	edge_t pend_data_q, edge_d, close_d;
	logic acc, dropped, is_first, has_edge;

	// sign-extend from bit COORD_BITS-1
	assign x_sh = x_coord <<< SHIFT;
	assign y_sh = y_coord <<< SHIFT;
	assign x_v  = x_sh >>> SHIFT;
	assign y_v  = y_sh >>> SHIFT;

	assign full     = pend_q || q_full;
	assign acc      = push && !full;
	assign dropped  = cnt_q >= CNT_W'(MAX_VERTICES);
	assign is_first = !dropped && (cnt_q == '0);
	assign has_edge = !dropped && (cnt_q != '0);

	assign prev_nx  = dropped ? prev_x_q : x_v;
	assign prev_ny  = dropped ? prev_y_q : y_v;
	assign first_nx = is_first ? x_v : first_x_q;
	assign first_ny = is_first ? y_v : first_y_q;

	assign edge_d = '{close: 1'b0, ovf: 1'b0,
		xp: prev_x_q, yp: prev_y_q, xc: x_v, yc: y_v};
	assign close_d = '{close: 1'b1, ovf: ovf_q || dropped,
		xp: prev_nx, yp: prev_ny, xc: first_nx, yc: first_ny};

	always_comb begin
		q_wr    = 1'b0;
		q_wdata = edge_d;
		if (pend_q) begin
			q_wr    = !q_full;
			q_wdata = pend_data_q;
		end else if (acc && has_edge) begin
			q_wr = 1'b1;
		end else if (acc && last_vertex) begin
			q_wr    = 1'b1;
			q_wdata = close_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			if (pend_q && !q_full) begin
				pend_q <= 1'b0;
			end
			if (acc) begin
				if (last_vertex) begin
					first_x_q <= '0;
					first_y_q <= '0;
					prev_x_q  <= '0;
					prev_y_q  <= '0;
					cnt_q     <= '0;
					ovf_q     <= 1'b0;
					// an edge, if any, goes out now; the closing item is held until the queue has room
					pend_q    <= has_edge;
				end else begin
					first_x_q <= first_nx;
					first_y_q <= first_ny;
					prev_x_q  <= prev_nx;
					prev_y_q  <= prev_ny;
					if (dropped) begin
						ovf_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last_vertex) begin
			pend_data_q <= close_d;
		end
	end

endmodule

/* rtl/pam_queue.sv */
// small queue of edge items between front end and arithmetic back end
module pam_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  pam_pkg::edge_t wdata,
	output logic           full,
	input  logic           rd,
	output pam_pkg::edge_t rdata,
	output logic           empty
);
	import pam_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	edge_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full) else $error("queue written while full");
	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty) else $error("queue read while empty");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* rtl/pam_back.sv */
// arithmetic back end: shared multiplier sequencer, sums, divide by three, result register
module pam_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pam_pkg::edge_t                       q_rdata,
	input  logic                                 q_empty,
	output logic                                 q_rd,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [pam_pkg::AREA_OUT_W-1:0]       twice_area,
	output logic [pam_pkg::MOM_OUT_W-1:0]        moment_about_x,
	output logic [pam_pkg::MOM_OUT_W-1:0]        moment_about_y,
	output logic [pam_pkg::MOM_OUT_W-1:0]        product_moment,
	output logic                                 overflow
);
	import pam_pkg::*;

	localparam logic [2:0] THREE = 3'd3;

	// one quotient digit per call: remainder and next digit in, digit shifted in at the bottom
	function automatic logic [DIV_BITS+1:0] div3_step(
		input logic [DIV_BITS-1:0] d,
		input logic [1:0]          r
	);
		logic [DIV_DIGIT+1:0]         v;
		logic [DIV_DIGIT+RECIP_W+1:0] p;
		logic [DIV_DIGIT-1:0]         q;
		logic [DIV_DIGIT+1:0]         rem;
		v   = {r, d[DIV_BITS-1 -: DIV_DIGIT]};
		p   = v * RECIP_3;
		q   = p[RECIP_SHIFT +: DIV_DIGIT];
		rem = v - (DIV_DIGIT+2)'(q) * (DIV_DIGIT+2)'(THREE);
		return {rem[1:0], d[DIV_BITS-DIV_DIGIT-1:0], q};
	endfunction

	back_state_t state_q, state_d;
	step_t step_q, tag_q, last_step;
	logic tvld_q, issue, load_abs, div_run, load_out, out_vld_q, ovf_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic [CROSS_W-1:0] p0_q, p1_q, c_q, sx_q, sy_q, c_new;
	logic [TERM_W-1:0] t_q;
	logic [AREA_W-1:0] area_q, area_mag;
	logic [AXIS_W-1:0] xs_q, ys_q, xs_mag, ys_mag;
	logic [PRODSUM_W-1:0] ps_q, ps_mag;
	logic [AREA_OUT_W-1:0] area_res_q;
	logic [DIV_BITS-1:0] dx_q, dy_q, dp_q;
	logic [1:0] rx_q, ry_q, rp_q;
	logic [DIV_BITS+1:0] nx, ny, np;

	logic [AREA_OUT_W-1:0] twice_area_q;
	logic [MOM_OUT_W-1:0] mx_q, my_q, mp_q;
	logic ovf_out_q;

	function automatic logic signed [MUL_W-1:0] ext_c(input logic signed [COORD_W-1:0] v);
		return {{(MUL_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

	assign last_step = q_rdata.close ? STEP_XCYP : STEP_MP;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_RUN: begin
				if (q_rd && q_rdata.close) state_d = BK_DRAIN;
			end
			BK_DRAIN: state_d = BK_ABS;
			BK_ABS:   state_d = BK_DIV;
			BK_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = BK_DONE;
			end
			BK_DONE: begin
				if (load_out) state_d = BK_RUN;
			end
			default: state_d = BK_RUN;
		endcase
	end

	// state outputs
	always_comb begin
		issue    = (state_q == BK_RUN) && !q_empty;
		q_rd     = issue && (step_q == last_step);
		load_abs = state_q == BK_ABS;
		div_run  = state_q == BK_DIV;
		load_out = (state_q == BK_DONE) && (!out_vld_q || pop);
	end

	always_comb begin
		mul_a = ext_c(q_rdata.xp);
		mul_b = ext_c(q_rdata.yc);
		case (step_q)
			STEP_XPYC: begin mul_a = ext_c(q_rdata.xp); mul_b = ext_c(q_rdata.yc); end
			STEP_XCYP: begin mul_a = ext_c(q_rdata.xc); mul_b = ext_c(q_rdata.yp); end
			STEP_YPYP: begin mul_a = ext_c(q_rdata.yp); mul_b = ext_c(q_rdata.yp); end
			STEP_YPYC: begin mul_a = ext_c(q_rdata.yp); mul_b = ext_c(q_rdata.yc); end
			STEP_YCYC: begin mul_a = ext_c(q_rdata.yc); mul_b = ext_c(q_rdata.yc); end
			STEP_XPXP: begin mul_a = ext_c(q_rdata.xp); mul_b = ext_c(q_rdata.xp); end
			STEP_XPXC: begin mul_a = ext_c(q_rdata.xp); mul_b = ext_c(q_rdata.xc); end
			STEP_XCXC: begin mul_a = ext_c(q_rdata.xc); mul_b = ext_c(q_rdata.xc); end
			STEP_XPYP: begin mul_a = ext_c(q_rdata.xp); mul_b = ext_c(q_rdata.yp); end
			STEP_XCYC: begin mul_a = ext_c(q_rdata.xc); mul_b = ext_c(q_rdata.yc); end
			STEP_MX: begin mul_a = {sx_q[CROSS_W-1], sx_q}; mul_b = {c_q[CROSS_W-1], c_q}; end
			STEP_MY: begin mul_a = {sy_q[CROSS_W-1], sy_q}; mul_b = {c_q[CROSS_W-1], c_q}; end
			STEP_MP: begin mul_a = t_q; mul_b = {c_q[CROSS_W-1], c_q}; end
			default: ;
		endcase
	end

	assign c_new = p0_q - prod_q[CROSS_W-1:0];

	assign area_mag = area_q[AREA_W-1] ? (~area_q + AREA_W'(1)) : area_q;
	assign xs_mag   = xs_q[AXIS_W-1] ? (~xs_q + AXIS_W'(1)) : xs_q;
	assign ys_mag   = ys_q[AXIS_W-1] ? (~ys_q + AXIS_W'(1)) : ys_q;
	assign ps_mag   = ps_q[PRODSUM_W-1] ? (~ps_q + PRODSUM_W'(1)) : ps_q;

	assign nx = div3_step(dx_q, rx_q);
	assign ny = div3_step(dy_q, ry_q);
	assign np = div3_step(dp_q, rp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_RUN;
			step_q    <= STEP_XPYC;
			tvld_q    <= 1'b0;
			out_vld_q <= 1'b0;
			div_cnt_q <= '0;
			area_q    <= '0;
			xs_q      <= '0;
			ys_q      <= '0;
			ps_q      <= '0;
		end else begin
			state_q <= state_d;
			tvld_q  <= issue;
			if (issue) begin
				step_q <= q_rd ? STEP_XPYC : step_t'(step_q + 4'd1);
			end
			if (load_abs) begin
				div_cnt_q <= '0;
			end else if (div_run) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			if (load_out) begin
				area_q <= '0;
				xs_q   <= '0;
				ys_q   <= '0;
				ps_q   <= '0;
			end else if (tvld_q) begin
				case (tag_q)
					STEP_XCYP: area_q <= area_q + {{(AREA_W-CROSS_W){c_new[CROSS_W-1]}}, c_new};
					STEP_MX:   xs_q <= xs_q + {{(AXIS_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
					STEP_MY:   ys_q <= ys_q + {{(AXIS_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
					STEP_MP:   ps_q <= ps_q + {{(PRODSUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
					default: ;
				endcase
			end
		end
	end

	// multiplier product, per-edge partial terms, divider and result registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		tag_q  <= step_q;
		if (q_rd && q_rdata.close) begin
			ovf_q <= q_rdata.ovf;
		end
		if (tvld_q) begin
			case (tag_q)
				STEP_XPYC: p0_q <= prod_q[CROSS_W-1:0];
				STEP_XCYP: begin
					p1_q <= prod_q[CROSS_W-1:0];
					c_q  <= c_new;
				end
				STEP_YPYP: sx_q <= prod_q[CROSS_W-1:0];
				STEP_YPYC: sx_q <= sx_q + prod_q[CROSS_W-1:0];
				STEP_YCYC: sx_q <= sx_q + prod_q[CROSS_W-1:0];
				STEP_XPXP: sy_q <= prod_q[CROSS_W-1:0];
				STEP_XPXC: sy_q <= sy_q + prod_q[CROSS_W-1:0];
				STEP_XCXC: sy_q <= sy_q + prod_q[CROSS_W-1:0];
				STEP_XPYP: t_q <= {p0_q[CROSS_W-1], p0_q} + {p1_q[CROSS_W-1], p1_q}
					+ {prod_q[CROSS_W-1:0], 1'b0};
				STEP_XCYC: t_q <= t_q + {prod_q[CROSS_W-1:0], 1'b0};
				default: ;
			endcase
		end
		if (load_abs) begin
			area_res_q <= area_mag[AREA_OUT_W-1:0];
			// divide by 12 and 24: drop the power-of-two part first
			dx_q <= DIV_BITS'(xs_mag[AXIS_W-1:2]);
			dy_q <= DIV_BITS'(ys_mag[AXIS_W-1:2]);
			dp_q <= DIV_BITS'(ps_mag[PRODSUM_W-1:3]);
			rx_q <= '0;
			ry_q <= '0;
			rp_q <= '0;
		end else if (div_run) begin
			{rx_q, dx_q} <= nx;
			{ry_q, dy_q} <= ny;
			{rp_q, dp_q} <= np;
		end
		if (load_out) begin
			twice_area_q <= area_res_q;
			mx_q         <= dx_q[MOM_OUT_W-1:0];
			my_q         <= dy_q[MOM_OUT_W-1:0];
			mp_q         <= dp_q[MOM_OUT_W-1:0];
			ovf_out_q    <= ovf_q;
		end
	end

	assign empty          = !out_vld_q;
	assign twice_area     = twice_area_q;
	assign moment_about_x = mx_q;
	assign moment_about_y = my_q;
	assign product_moment = mp_q;
	assign overflow       = ovf_out_q;

`ifndef SYNTHESIS
	a_no_issue_off_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> (state_q == BK_RUN)) else $error("queue read outside run state");
	a_close_then_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(q_rd && q_rdata.close) |=> (state_q == BK_DRAIN && tvld_q && tag_q == STEP_XCYP))
		else $error("closing edge did not drain");
	a_load_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_vld_q && state_q == BK_RUN))
		else $error("result load out of sequence");
`endif

endmodule
